// ===== src/csf_pkg.sv =====
// Shared types and constants for the coherence snoop filter.
`default_nettype none
package csf_pkg;

	localparam int MAX_CACHES = 8;
	localparam int TAG_BITS   = 10;
	localparam int CMD_W      = 2;
	localparam int ID_W       = 3;
	localparam int CFG_W      = 4;
	localparam int CNT_W      = 32;
	localparam int POP_W      = $clog2(MAX_CACHES + 1);

	localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(MAX_CACHES);

	typedef enum logic [CMD_W-1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_EVICT = 2'd2,
		CMD_RSVD  = 2'd3
	} csf_cmd_t;

	typedef struct packed {
		logic                  dirty;
		logic [MAX_CACHES-1:0] sharers;
	} csf_entry_t;

	localparam int ENTRY_W = $bits(csf_entry_t);

	typedef struct packed {
		logic                  err;
		logic                  wb;
		logic                  wr;
		logic [MAX_CACHES-1:0] inv;
		csf_entry_t            entry;
	} csf_upd_t;

	typedef struct packed {
		logic [CNT_W-1:0] writes;
		logic [CNT_W-1:0] invals;
		logic [CNT_W-1:0] wbacks;
	} csf_cnt_t;

endpackage
`default_nettype wire

// ===== src/csf_req_if.sv =====
// Request channel: command, tag and requesting cache.
`default_nettype none
interface csf_req_if;
	import csf_pkg::*;

	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [TAG_BITS-1:0] tag;
	logic [ID_W-1:0]     cache_id;

	modport source (output valid, cmd, tag, cache_id, input ready);
	modport sink (input valid, cmd, tag, cache_id, output ready);
endinterface
`default_nettype wire

// ===== src/csf_rsp_if.sv =====
// Response channel: invalidate mask, writeback, error and counters.
`default_nettype none
interface csf_rsp_if;
	import csf_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [MAX_CACHES-1:0] invalidate_mask;
	logic                  writeback;
	logic                  error;
	logic [CNT_W-1:0]      write_count;
	logic [CNT_W-1:0]      invalidate_count;
	logic [CNT_W-1:0]      writeback_count;

	modport source (output valid, invalidate_mask, writeback, error, write_count,
		invalidate_count, writeback_count, input ready);
	modport sink (input valid, invalidate_mask, writeback, error, write_count,
		invalidate_count, writeback_count, output ready);
endinterface
`default_nettype wire

// ===== src/csf_dir_ram.sv =====
// Directory RAM: one write port, one read port with registered read data.
`default_nettype none
module csf_dir_ram #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 9
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output      logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [(1 << ADDR_W)];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== src/csf_lookup.sv =====
// Directory update rules: next entry, invalidate mask, writeback and error.
`default_nettype none
module csf_lookup (
	input  wire logic [csf_pkg::CMD_W-1:0] cmd,
	input  wire logic [csf_pkg::ID_W-1:0]  cache_id,
	input  wire logic [csf_pkg::CFG_W-1:0] active,
	input  wire csf_pkg::csf_entry_t       entry,
	output      csf_pkg::csf_upd_t         upd
);
	import csf_pkg::*;

	csf_cmd_t              cmd_e;
	logic [MAX_CACHES-1:0] me;
	logic [MAX_CACHES-1:0] sh;
	logic [MAX_CACHES-1:0] inv;
	logic                  dirty;
	logic                  err;
	logic                  wb;
	logic                  wr;
	logic                  bad_id;

	assign cmd_e  = csf_cmd_t'(cmd);
	assign bad_id = ({1'b0, cache_id} >= active) || (int'(cache_id) >= MAX_CACHES);

	always_comb begin
		me           = '0;
		me[cache_id] = 1'b1;
		sh           = entry.sharers;
		dirty        = entry.dirty;
		err          = bad_id;
		wb           = 1'b0;
		wr           = 1'b0;
		inv          = '0;
		unique case (cmd_e) inside
			CMD_READ, CMD_WRITE: begin
				if (!(|(sh & me)) && dirty) begin
					wb    = 1'b1;
					dirty = 1'b0;
				end
				if (cmd_e == CMD_WRITE) begin
					wr    = 1'b1;
					dirty = 1'b1;
					inv   = sh & ~me;
					sh    = sh & me;
				end
				sh = sh | me;
			end
			CMD_EVICT: begin
				if (!(|(sh & me))) begin
					err = 1'b1;
				end else begin
					wb    = dirty;
					dirty = 1'b0;
					sh    = sh & ~me;
				end
			end
			default: begin
				err = 1'b1;
			end
		endcase
		if (err) begin
			wb  = 1'b0;
			wr  = 1'b0;
			inv = '0;
		end
		upd.err           = err;
		upd.wb            = wb;
		upd.wr            = wr;
		upd.inv           = inv;
		upd.entry.sharers = sh;
		upd.entry.dirty   = dirty;
	end

endmodule
`default_nettype wire

// ===== src/csf_stats.sv =====
// Saturating write, invalidate and writeback counters.
`default_nettype none
module csf_stats (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire csf_pkg::csf_upd_t upd,
	output      csf_pkg::csf_cnt_t cnt_next
);
	import csf_pkg::*;

	csf_cnt_t         cnt_q;
	logic [POP_W-1:0] pop;
	logic [CNT_W:0]   sum_wr;
	logic [CNT_W:0]   sum_inv;
	logic [CNT_W:0]   sum_wb;

	always_comb begin
		pop = '0;
		for (int i = 0; i < MAX_CACHES; i++) begin
			pop = pop + POP_W'(upd.inv[i]);
		end
	end

	assign sum_wr  = {1'b0, cnt_q.writes} + (CNT_W + 1)'(upd.wr);
	assign sum_inv = {1'b0, cnt_q.invals} + (CNT_W + 1)'(pop);
	assign sum_wb  = {1'b0, cnt_q.wbacks} + (CNT_W + 1)'(upd.wb);

	assign cnt_next.writes = sum_wr[CNT_W]  ? '1 : sum_wr[CNT_W-1:0];
	assign cnt_next.invals = sum_inv[CNT_W] ? '1 : sum_inv[CNT_W-1:0];
	assign cnt_next.wbacks = sum_wb[CNT_W]  ? '1 : sum_wb[CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (fire) begin
			cnt_q <= cnt_next;
		end
	end

endmodule
`default_nettype wire

// ===== src/coherence_snoop_filter.sv =====
// Coherence snoop filter top level: sharer-vector directory with counters.
//
// Requests enter on req (cmd, tag, cache_id) and each produces exactly one
// transfer on rsp: invalidate mask, writeback flag, error flag and the three
// counters after the request. The directory is a 1024-entry RAM indexed by
// tag; the entry read at acceptance is updated in the lookup stage and is
// written back as it fires, with a bypass for a back-to-back same-tag request.
// A request passes the lookup stage and output register. Throughput: one
// request per cycle unless rsp stalls, set by the single RAM read-modify-write.
// cfg_we/cfg_wdata load active_caches (reset 8); write it only while idle.
// Reset: counters clear at once; the directory is then cleared one entry per
// cycle through all 1024 entries, during which req.ready stays low.
// Stall: a result waits in the output register; one more request is held in
// the lookup stage, after which req.ready drops until rsp.ready returns.
`default_nettype none
module coherence_snoop_filter (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	csf_req_if.sink                         req,
	csf_rsp_if.source                       rsp,
	input  wire logic                       cfg_we,
	input  wire logic [csf_pkg::CFG_W-1:0]  cfg_wdata
);
	import csf_pkg::*;

	logic [TAG_BITS:0]     clr_q;
	logic                  clr_done;
	logic [CFG_W-1:0]      active_q;

	logic                  valid_s1;
	logic [CMD_W-1:0]      cmd_s1;
	logic [TAG_BITS-1:0]   tag_s1;
	logic [ID_W-1:0]       id_s1;
	logic                  fwd_s1;
	csf_entry_t            fwd_entry_s1;

	logic [ENTRY_W-1:0]    rd_raw;
	csf_entry_t            entry_cur;
	csf_upd_t              upd;
	csf_cnt_t              cnt_next;

	logic                  accept;
	logic                  adv_s1;
	logic                  fire_s1;
	logic                  wr_en;
	logic [TAG_BITS-1:0]   wr_addr;
	csf_entry_t            wr_data;

	logic                  rsp_valid_q;
	logic [MAX_CACHES-1:0] inv_q;
	logic                  wb_q;
	logic                  err_q;
	csf_cnt_t              cnt_q;

	assign clr_done  = clr_q[TAG_BITS];
	assign adv_s1    = !rsp_valid_q || rsp.ready;
	assign fire_s1   = valid_s1 && adv_s1;
	assign req.ready = clr_done && (!valid_s1 || adv_s1);
	assign accept    = req.valid && req.ready;

	assign wr_en   = !clr_done || (fire_s1 && !upd.err);
	assign wr_addr = clr_done ? tag_s1 : clr_q[TAG_BITS-1:0];
	assign wr_data = clr_done ? upd.entry : '0;

	assign entry_cur = fwd_s1 ? fwd_entry_s1 : csf_entry_t'(rd_raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!clr_done) begin
			clr_q <= clr_q + (TAG_BITS + 1)'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	csf_dir_ram #(
		.ADDR_W (TAG_BITS),
		.DATA_W (ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (accept),
		.raddr (req.tag),
		.rdata (rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// bypass the entry being written in the same cycle as the read
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1       <= req.cmd;
			tag_s1       <= req.tag;
			id_s1        <= req.cache_id;
			fwd_s1       <= wr_en && (wr_addr == req.tag);
			fwd_entry_s1 <= wr_data;
		end
	end

	csf_lookup u_lookup (
		.cmd      (cmd_s1),
		.cache_id (id_s1),
		.active   (active_q),
		.entry    (entry_cur),
		.upd      (upd)
	);

	csf_stats u_stats (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire_s1),
		.upd      (upd),
		.cnt_next (cnt_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			inv_q <= upd.inv;
			wb_q  <= upd.wb;
			err_q <= upd.err;
			cnt_q <= cnt_next;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.invalidate_mask  = inv_q;
	assign rsp.writeback        = wb_q;
	assign rsp.error            = err_q;
	assign rsp.write_count      = cnt_q.writes;
	assign rsp.invalidate_count = cnt_q.invals;
	assign rsp.writeback_count  = cnt_q.wbacks;

	a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_done |-> !valid_s1 && !rsp_valid_q)
		else $error("request in flight during directory clear");

	a_error_is_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && err_q |-> !wb_q && (inv_q == '0))
		else $error("rejected request reports writeback or invalidation");

	a_no_self_invalidate: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |-> !upd.inv[id_s1])
		else $error("requester found in its own invalidate mask");

	a_wb_count_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && !upd.wb |=> rsp.writeback_count == $past(cnt_next.wbacks))
		else $error("writeback counter moved without a writeback");

endmodule
`default_nettype wire
